[design/rrs_pkg.sv]
// rrs_pkg: widths, types and helper functions for the running return statistics block
// no dependencies; used by every other file of the block
package rrs_pkg;

    // field widths
    localparam int AMOUNT_BITS   = 32;
    localparam int TOTAL_BITS    = 48;
    localparam int FRACTION_BITS = 16;
    localparam int COUNT_W       = 32;
    localparam int RET_W         = AMOUNT_BITS + 1;
    localparam int RATIO_W       = 32;
    localparam int M2_W          = 64;

    // shared divider geometry
    localparam int QUO_W         = 64;
    localparam int DIVISOR_W     = 32;
    localparam int STEP_W        = 7;
    localparam int RATIO_STEPS   = RET_W + FRACTION_BITS;
    localparam int MEAN_STEPS    = RATIO_W;
    localparam int VAR_STEPS     = M2_W;

    // input item kinds
    localparam logic KIND_SPIN  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [TOTAL_BITS-1:0] total_t;
    typedef logic [RET_W-1:0]      ret_t;
    typedef logic [RATIO_W-1:0]    ratio_t;
    typedef logic [M2_W-1:0]       m2_t;

    // request to the shared divider
    typedef struct packed {
        logic                  start;
        logic [QUO_W-1:0]      dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [STEP_W-1:0]     steps;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quotient;
    } div_rsp_t;

    // one-cycle update strobe to the tally block
    typedef struct packed {
        logic                    load;
        logic                    clear;
        logic [AMOUNT_BITS-1:0]  wager;
        logic [AMOUNT_BITS-1:0]  won;
        logic [AMOUNT_BITS-1:0]  consolation;
        ret_t                    ret;
    } tally_req_t;

    // counters, totals and extremes held by the tally block
    typedef struct packed {
        count_t  spin_count;
        count_t  win_count;
        total_t  wager_sum;
        total_t  won_sum;
        total_t  consolation_sum;
        ret_t    best_return;
        count_t  longest_run;
    } tally_t;

    // saturating increment of a count
    function automatic count_t count_inc(input count_t a);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {{COUNT_W{1'b0}}, 1'b1};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    // saturating accumulate of an amount into a total
    function automatic total_t total_add(input total_t a, input logic [AMOUNT_BITS-1:0] b);
        logic [TOTAL_BITS:0] s;
        s = {1'b0, a} + (TOTAL_BITS+1)'(b);
        return s[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : s[TOTAL_BITS-1:0];
    endfunction

endpackage

[design/rrs_if.sv]
// rrs_if: valid/ready channel interfaces for spin items and report items
// depends on rrs_pkg
interface rrs_in_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic [rrs_pkg::AMOUNT_BITS-1:0]  wager;
    logic [rrs_pkg::AMOUNT_BITS-1:0]  won;
    logic [rrs_pkg::AMOUNT_BITS-1:0]  consolation;

    modport source (output valid, kind, wager, won, consolation, input ready);
    modport sink   (input valid, kind, wager, won, consolation, output ready);
endinterface

interface rrs_out_if;
    logic                  valid;
    logic                  ready;
    rrs_pkg::count_t       spin_count;
    rrs_pkg::count_t       win_count;
    rrs_pkg::total_t       wager_sum;
    rrs_pkg::total_t       won_sum;
    rrs_pkg::total_t       consolation_sum;
    rrs_pkg::ret_t         largest_return;
    rrs_pkg::count_t       longest_losing_run;
    rrs_pkg::ratio_t       avg_ratio;
    rrs_pkg::m2_t          ratio_variance;

    modport source (output valid, spin_count, win_count, wager_sum, won_sum, consolation_sum,
                    largest_return, longest_losing_run, avg_ratio, ratio_variance,
                    input ready);
    modport sink   (input valid, spin_count, win_count, wager_sum, won_sum, consolation_sum,
                    largest_return, longest_losing_run, avg_ratio, ratio_variance,
                    output ready);
endinterface

[design/rrs_divider.sv]
// rrs_divider: shared radix-2 restoring divider, one quotient bit per cycle
// depends on rrs_pkg; dividend arrives left-aligned, quotient lands in the low bits
module rrs_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  rrs_pkg::div_req_t  req,
    output rrs_pkg::div_rsp_t  rsp
);

    logic [rrs_pkg::DIVISOR_W-1:0]  rem_reg;
    logic [rrs_pkg::DIVISOR_W-1:0]  rem_next;
    logic [rrs_pkg::QUO_W-1:0]      quo_reg;
    logic [rrs_pkg::QUO_W-1:0]      quo_next;
    logic [rrs_pkg::DIVISOR_W-1:0]  dsr_reg;
    logic [rrs_pkg::STEP_W-1:0]     count_reg;
    logic                           done_reg;

    logic [rrs_pkg::DIVISOR_W:0]    shifted;
    logic [rrs_pkg::DIVISOR_W:0]    diff;
    logic                           fits;

    // one restoring step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[rrs_pkg::QUO_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? diff[rrs_pkg::DIVISOR_W-1:0] : shifted[rrs_pkg::DIVISOR_W-1:0];
        quo_next = {quo_reg[rrs_pkg::QUO_W-2:0], fits};
    end

    // control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (req.start)
        begin
            count_reg <= req.steps;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (count_reg == rrs_pkg::STEP_W'(1));
            if (count_reg != '0)
            begin
                count_reg <= count_reg - rrs_pkg::STEP_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (count_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[design/rrs_tally.sv]
// rrs_tally: saturating counts, totals, largest return and losing streaks
// depends on rrs_pkg; registers the update from the cycle a spin or clear item is taken
module rrs_tally
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrs_pkg::tally_req_t  req,
    output rrs_pkg::tally_t      stats
);

    rrs_pkg::tally_t  stats_reg;
    rrs_pkg::tally_t  stats_next;
    rrs_pkg::count_t  run_reg;
    rrs_pkg::count_t  run_next;

    // next values for one spin
    always_comb
    begin
        stats_next = stats_reg;
        run_next   = run_reg;
        if (req.clear)
        begin
            stats_next = '0;
            run_next   = '0;
        end
        else if (req.load)
        begin
            stats_next.spin_count      = rrs_pkg::count_inc(stats_reg.spin_count);
            stats_next.wager_sum       = rrs_pkg::total_add(stats_reg.wager_sum, req.wager);
            stats_next.won_sum         = rrs_pkg::total_add(stats_reg.won_sum, req.won);
            stats_next.consolation_sum = rrs_pkg::total_add(stats_reg.consolation_sum,
                                                            req.consolation);
            if (req.won != '0)
            begin
                stats_next.win_count = rrs_pkg::count_inc(stats_reg.win_count);
                run_next             = '0;
            end
            else
            begin
                run_next = rrs_pkg::count_inc(run_reg);
                if (run_next > stats_reg.longest_run)
                begin
                    stats_next.longest_run = run_next;
                end
            end
            if (req.ret > stats_reg.best_return)
            begin
                stats_next.best_return = req.ret;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg <= '0;
            run_reg   <= '0;
        end
        else
        begin
            stats_reg <= stats_next;
            run_reg   <= run_next;
        end
    end

    assign stats = stats_reg;

endmodule

[design/running_return_statistics_unit.sv]
// running_return_statistics_unit: top level, sequencer and Welford mean/M2 datapath
// depends on rrs_pkg, rrs_if, rrs_divider, rrs_tally
//
//  channel  dir  handshake             payload
//  spin     in   spin.valid/ready      kind, wager, won, consolation
//  report   out  report.valid/ready    counts, totals, largest return, run, mean, variance
//
// a spin item uses the shared radix-2 divider for the ratio, the mean step and the variance,
// in that order, with sequencer states between the divisions
// a clear item goes from idle straight to the finish state; a spin with zero wager skips the ratio division
// rst_n clears all statistics at once; no clearing pass
// spin.ready is high only while the sequencer is idle; the report register holds a
// finished result while the next item is taken, and the sequencer waits if it is still held
module running_return_statistics_unit
(
    input  logic        clk,
    input  logic        rst_n,
    rrs_in_if.sink      spin,
    rrs_out_if.source   report
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RATIO  = 4'd1;
    localparam logic [3:0] ST_MEAN   = 4'd2;
    localparam logic [3:0] ST_STEP   = 4'd3;
    localparam logic [3:0] ST_MUL    = 4'd4;
    localparam logic [3:0] ST_ACC    = 4'd5;
    localparam logic [3:0] ST_VAR    = 4'd6;
    localparam logic [3:0] ST_VARW   = 4'd7;
    localparam logic [3:0] ST_FINISH = 4'd8;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;

    rrs_pkg::div_req_t    div_req;
    rrs_pkg::div_rsp_t    div_rsp;
    rrs_pkg::tally_req_t  tally_req;
    rrs_pkg::tally_t      stats;

    rrs_pkg::ratio_t  x_reg;
    rrs_pkg::ratio_t  mean_reg;
    rrs_pkg::ratio_t  d1_reg;
    rrs_pkg::ratio_t  d2_reg;
    logic             up_reg;
    logic [2*rrs_pkg::RATIO_W-1:0]  prod_reg;
    rrs_pkg::m2_t     m2_reg;
    rrs_pkg::m2_t     var_reg;

    logic             out_valid_reg;
    rrs_pkg::tally_t  out_stats_reg;
    rrs_pkg::ratio_t  out_mean_reg;
    rrs_pkg::m2_t     out_var_reg;

    logic             take;
    logic             out_free;
    rrs_pkg::ret_t    ret;
    rrs_pkg::ratio_t  ratio_q;
    rrs_pkg::ratio_t  mean_step;
    rrs_pkg::ratio_t  new_mean;
    logic [rrs_pkg::M2_W:0]  m2_sum;

    assign spin.ready = (state_reg == ST_IDLE);
    assign take       = spin.valid && spin.ready;
    assign out_free   = !out_valid_reg || report.ready;
    assign ret        = {1'b0, spin.won} + {1'b0, spin.consolation};

    // saturate the ratio quotient, form the mean update and form the M2 sum
    always_comb
    begin
        if (div_rsp.quotient[rrs_pkg::RATIO_STEPS-1:rrs_pkg::RATIO_W] != '0)
        begin
            ratio_q = {rrs_pkg::RATIO_W{1'b1}};
        end
        else
        begin
            ratio_q = div_rsp.quotient[rrs_pkg::RATIO_W-1:0];
        end
        mean_step = div_rsp.quotient[rrs_pkg::RATIO_W-1:0];
        new_mean  = up_reg ? (mean_reg + mean_step) : (mean_reg - mean_step);
        m2_sum    = {1'b0, m2_reg}
                  + (rrs_pkg::M2_W+1)'(prod_reg >> rrs_pkg::FRACTION_BITS);
    end

    // tally strobe
    always_comb
    begin
        tally_req.load        = take && (spin.kind == rrs_pkg::KIND_SPIN);
        tally_req.clear       = take && (spin.kind == rrs_pkg::KIND_CLEAR);
        tally_req.wager       = spin.wager;
        tally_req.won         = spin.won;
        tally_req.consolation = spin.consolation;
        tally_req.ret         = ret;
    end

    // divider requests
    always_comb
    begin
        div_req = '0;
        case (state_reg)
            ST_IDLE:
            begin
                div_req.start    = tally_req.load && (spin.wager != '0);
                div_req.dividend = rrs_pkg::QUO_W'(ret) << (rrs_pkg::QUO_W - rrs_pkg::RET_W);
                div_req.divisor  = spin.wager;
                div_req.steps    = rrs_pkg::STEP_W'(rrs_pkg::RATIO_STEPS);
            end
            ST_MEAN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = rrs_pkg::QUO_W'(x_reg >= mean_reg ? x_reg - mean_reg
                                                                      : mean_reg - x_reg)
                                   << (rrs_pkg::QUO_W - rrs_pkg::RATIO_W);
                div_req.divisor  = stats.spin_count;
                div_req.steps    = rrs_pkg::STEP_W'(rrs_pkg::MEAN_STEPS);
            end
            ST_VAR:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = m2_reg;
                div_req.divisor  = stats.spin_count;
                div_req.steps    = rrs_pkg::STEP_W'(rrs_pkg::VAR_STEPS);
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tally_req.clear)
                begin
                    state_next = ST_FINISH;
                end
                else if (tally_req.load)
                begin
                    state_next = (spin.wager != '0) ? ST_RATIO : ST_MEAN;
                end
            end
            ST_RATIO:  state_next = div_rsp.done ? ST_MEAN : ST_RATIO;
            ST_MEAN:   state_next = ST_STEP;
            ST_STEP:   state_next = div_rsp.done ? ST_MUL : ST_STEP;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = ST_VAR;
            ST_VAR:    state_next = ST_VARW;
            ST_VARW:   state_next = div_rsp.done ? ST_FINISH : ST_VARW;
            ST_FINISH: state_next = out_free ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Welford state: running mean and M2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            m2_reg   <= '0;
        end
        else if (tally_req.clear)
        begin
            mean_reg <= '0;
            m2_reg   <= '0;
        end
        else if ((state_reg == ST_STEP) && div_rsp.done)
        begin
            mean_reg <= new_mean;
        end
        else if (state_reg == ST_ACC)
        begin
            m2_reg <= m2_sum[rrs_pkg::M2_W] ? {rrs_pkg::M2_W{1'b1}}
                                            : m2_sum[rrs_pkg::M2_W-1:0];
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                x_reg   <= '0;
                var_reg <= '0;
            end
            ST_RATIO:
            begin
                if (div_rsp.done)
                begin
                    x_reg <= ratio_q;
                end
            end
            ST_MEAN:
            begin
                up_reg <= x_reg >= mean_reg;
                d1_reg <= (x_reg >= mean_reg) ? x_reg - mean_reg : mean_reg - x_reg;
            end
            ST_STEP:
            begin
                d2_reg <= up_reg ? x_reg - new_mean : new_mean - x_reg;
            end
            ST_MUL:
            begin
                prod_reg <= d1_reg * d2_reg;
            end
            ST_VARW:
            begin
                if (div_rsp.done)
                begin
                    var_reg <= div_rsp.quotient;
                end
            end
            default:
            begin
            end
        endcase
    end

    // report register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_stats_reg <= stats;
            out_mean_reg  <= mean_reg;
            out_var_reg   <= var_reg;
        end
    end

    assign report.valid              = out_valid_reg;
    assign report.spin_count         = out_stats_reg.spin_count;
    assign report.win_count          = out_stats_reg.win_count;
    assign report.wager_sum          = out_stats_reg.wager_sum;
    assign report.won_sum            = out_stats_reg.won_sum;
    assign report.consolation_sum    = out_stats_reg.consolation_sum;
    assign report.largest_return     = out_stats_reg.best_return;
    assign report.longest_losing_run = out_stats_reg.longest_run;
    assign report.avg_ratio          = out_mean_reg;
    assign report.ratio_variance     = out_var_reg;

    rrs_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rrs_tally u_tally
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tally_req),
        .stats (stats)
    );

endmodule

[design/rrs_checker.sv]
// rrs_checker: port-level assertions for running_return_statistics_unit
// depends on rrs_pkg; attached to the top level by the bind at the end of the file
module rrs_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             out_valid,
    input  logic             out_ready,
    input  rrs_pkg::count_t  spin_count,
    input  rrs_pkg::count_t  win_count,
    input  rrs_pkg::count_t  longest_losing_run,
    input  rrs_pkg::ratio_t  avg_ratio,
    input  rrs_pkg::m2_t     ratio_variance
);

    // the block works on one item at a time
    property p_busy_after_take;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready;
    endproperty
    a_busy_after_take: assert property (p_busy_after_take)
        else $error("spin ready again straight after an item was taken");

    // counts never exceed the spin count
    property p_counts_bounded;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (win_count <= spin_count) && (longest_losing_run <= spin_count);
    endproperty
    a_counts_bounded: assert property (p_counts_bounded)
        else $error("win count or losing run above spin count");

    // an empty session reports no mean and no variance
    property p_empty_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && (spin_count == '0) |-> (avg_ratio == '0) && (ratio_variance == '0);
    endproperty
    a_empty_zero: assert property (p_empty_zero)
        else $error("nonzero mean or variance with no spins");

    // a held report stays
    property p_report_held;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(spin_count) && $stable(ratio_variance);
    endproperty
    a_report_held: assert property (p_report_held)
        else $error("report item changed or dropped while stalled");

endmodule

bind running_return_statistics_unit rrs_checker u_rrs_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (spin.valid),
    .in_ready           (spin.ready),
    .out_valid          (report.valid),
    .out_ready          (report.ready),
    .spin_count         (report.spin_count),
    .win_count          (report.win_count),
    .longest_losing_run (report.longest_losing_run),
    .avg_ratio          (report.avg_ratio),
    .ratio_variance     (report.ratio_variance)
);

[tb/sv/tb.sv]
// tb: self-checking bench for running_return_statistics_unit, spin items in, report items out
// depends on rrs_pkg, rrs_if and the design files; predicts every report and checks it field by field
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int TARGET_ITEMS = 1350;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct packed {
        logic                             kind;
        logic [rrs_pkg::AMOUNT_BITS-1:0]  wager;
        logic [rrs_pkg::AMOUNT_BITS-1:0]  won;
        logic [rrs_pkg::AMOUNT_BITS-1:0]  consolation;
    } spin_item_t;

    typedef struct packed {
        rrs_pkg::count_t  spins;
        rrs_pkg::count_t  wins;
        rrs_pkg::total_t  wagered;
        rrs_pkg::total_t  paid;
        rrs_pkg::total_t  consoled;
        rrs_pkg::ret_t    best;
        rrs_pkg::count_t  longest_run;
        rrs_pkg::ratio_t  mean;
        rrs_pkg::m2_t     variance;
    } report_t;

    logic clk = 1'b0;
    logic rst_n;

    rrs_in_if  spin_ch ();
    rrs_out_if report_ch ();

    running_return_statistics_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .spin   (spin_ch),
        .report (report_ch)
    );

    // predicted session state
    rrs_pkg::count_t  n_spins;
    rrs_pkg::count_t  n_wins;
    rrs_pkg::total_t  sum_wager;
    rrs_pkg::total_t  sum_won;
    rrs_pkg::total_t  sum_cons;
    rrs_pkg::ret_t    top_return;
    rrs_pkg::count_t  run_now;
    rrs_pkg::count_t  run_worst;
    rrs_pkg::ratio_t  mean_q;
    rrs_pkg::m2_t     m2_acc;

    spin_item_t  spins_pending[$];
    report_t     reports_due[$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned spins_taken = 0;
    int unsigned clears_taken = 0;
    int unsigned reports_checked = 0;
    int unsigned spin_gap = 0;
    int unsigned report_stall = 0;
    logic        calm = 1'b0;
    logic        spin_taken = 1'b0;
    logic        report_taken = 1'b0;
    spin_item_t  next_item;
    report_t     got;

    // clock
    always #CLK_HALF clk = ~clk;

    task automatic note_fault(input string what, input logic [63:0] seen, input logic [63:0] want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, seen, want);
    endtask

    function automatic rrs_pkg::count_t bump(input rrs_pkg::count_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic rrs_pkg::total_t add_capped(input rrs_pkg::total_t a,
                                                   input logic [rrs_pkg::AMOUNT_BITS-1:0] b);
        logic [rrs_pkg::TOTAL_BITS:0] s;
        s = {1'b0, a} + (rrs_pkg::TOTAL_BITS+1)'(b);
        return s[rrs_pkg::TOTAL_BITS] ? '1 : s[rrs_pkg::TOTAL_BITS-1:0];
    endfunction

    // advance the predicted statistics by one item and return the report it should give
    function automatic report_t apply_spin(input spin_item_t it);
        report_t        r;
        rrs_pkg::ret_t  payout;
        logic [63:0]    ratio;
        logic [63:0]    d1;
        logic [63:0]    d2;
        logic [63:0]    step;
        logic [63:0]    mean_next;
        logic [63:0]    prod;
        logic [64:0]    m2_sum;
        logic           rising;
        if (it.kind == rrs_pkg::KIND_CLEAR)
        begin
            n_spins    = '0;
            n_wins     = '0;
            sum_wager  = '0;
            sum_won    = '0;
            sum_cons   = '0;
            top_return = '0;
            run_now    = '0;
            run_worst  = '0;
            mean_q     = '0;
            m2_acc     = '0;
        end
        else
        begin
            n_spins   = bump(n_spins);
            sum_wager = add_capped(sum_wager, it.wager);
            sum_won   = add_capped(sum_won, it.won);
            sum_cons  = add_capped(sum_cons, it.consolation);
            if (it.won != '0)
            begin
                n_wins  = bump(n_wins);
                run_now = '0;
            end
            else
            begin
                run_now = bump(run_now);
                if (run_now > run_worst)
                    run_worst = run_now;
            end
            payout = {1'b0, it.won} + {1'b0, it.consolation};
            if (payout > top_return)
                top_return = payout;
            // return ratio in fixed point, saturating, zero for a free spin
            if (it.wager == '0)
                ratio = '0;
            else
            begin
                ratio = (64'(payout) << rrs_pkg::FRACTION_BITS) / 64'(it.wager);
                if (ratio > 64'hFFFF_FFFF)
                    ratio = 64'hFFFF_FFFF;
            end
            // welford mean and M2 step with magnitudes
            rising    = ratio >= 64'(mean_q);
            d1        = rising ? ratio - 64'(mean_q) : 64'(mean_q) - ratio;
            step      = d1 / 64'(n_spins);
            mean_next = rising ? 64'(mean_q) + step : 64'(mean_q) - step;
            if (mean_next > 64'hFFFF_FFFF)
                mean_next = 64'hFFFF_FFFF;
            mean_q    = mean_next[rrs_pkg::RATIO_W-1:0];
            d2        = rising ? ratio - mean_next : mean_next - ratio;
            prod      = (d1 * d2) >> rrs_pkg::FRACTION_BITS;
            m2_sum    = {1'b0, m2_acc} + {1'b0, prod};
            m2_acc    = m2_sum[64] ? '1 : m2_sum[63:0];
        end
        r.spins       = n_spins;
        r.wins        = n_wins;
        r.wagered     = sum_wager;
        r.paid        = sum_won;
        r.consoled    = sum_cons;
        r.best        = top_return;
        r.longest_run = run_worst;
        r.mean        = mean_q;
        r.variance    = (n_spins == '0) ? '0 : m2_acc / 64'(n_spins);
        return r;
    endfunction

    function automatic spin_item_t make_spin(input logic k, input logic [31:0] w,
                                             input logic [31:0] v, input logic [31:0] c);
        spin_item_t it;
        it.kind        = k;
        it.wager       = w;
        it.won         = v;
        it.consolation = c;
        return it;
    endfunction

    // mostly plausible play with random content, some wild values and the odd clear
    function automatic spin_item_t random_spin();
        spin_item_t   it;
        int unsigned  pick;
        logic [63:0]  prize;
        pick           = $urandom_range(0, 99);
        it.kind        = rrs_pkg::KIND_SPIN;
        it.wager       = 32'($urandom_range(1, 500));
        it.won         = '0;
        it.consolation = '0;
        if (pick < 2)
        begin
            it.kind        = rrs_pkg::KIND_CLEAR;
            it.wager       = $urandom;
            it.won         = $urandom;
            it.consolation = $urandom;
        end
        else if (pick < 12)
        begin
            case ($urandom_range(0, 3))
                0:       it.wager = '0;
                1:       it.wager = 32'($urandom_range(1, 15));
                default: it.wager = $urandom;
            endcase
            it.won         = ($urandom_range(0, 2) == 0) ? '0 : $urandom;
            it.consolation = ($urandom_range(0, 1) == 0) ? '0 : $urandom;
            if (pick == 11)
            begin
                it.won = '1;
                it.consolation = '1;
            end
        end
        else
        begin
            if ($urandom_range(0, 9) == 0)
                it.wager = 32'($urandom_range(1, 32'h000F_FFFF));
            if ($urandom_range(0, 9) < 3)
            begin
                prize  = 64'(it.wager) * 64'($urandom_range(1, 50));
                it.won = prize[31:0];
            end
            if ($urandom_range(0, 9) == 0)
                it.consolation = 32'($urandom_range(1, 20));
        end
        return it;
    endfunction

    // idle length: mostly none or short, now and then long; none at all in calm stretches
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 40);
        return $urandom_range(100, 300);
    endfunction

    // stimulus and end of run
    initial
    begin
        rst_n                 = 1'b0;
        spin_ch.valid         = 1'b0;
        spin_ch.kind          = rrs_pkg::KIND_SPIN;
        spin_ch.wager         = '0;
        spin_ch.won           = '0;
        spin_ch.consolation   = '0;
        report_ch.ready       = 1'b0;
        n_spins    = '0;
        n_wins     = '0;
        sum_wager  = '0;
        sum_won    = '0;
        sum_cons   = '0;
        top_return = '0;
        run_now    = '0;
        run_worst  = '0;
        mean_q     = '0;
        m2_acc     = '0;

        // directed: extremes, free spins, ratio saturation edge, streaks, clears
        spins_pending.push_back(make_spin(rrs_pkg::KIND_CLEAR, '1, '1, '1));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 0, 0, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 1, 0, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 0, 5, 3));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, '1, '1, '1));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 1, '1, '1));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 1, 0, '1));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 1, 32'h0000_FFFF, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 1, 32'h0000_FFFF, 1));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 100, 250, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 3, 1, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 10, 0, 1));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 10, 0, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 10, 0, 2));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 10, 0, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 10, 20, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, '1, 1, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 32'h8000_0000, 32'h5555_5555,
                                          32'hAAAA_AAAA));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_CLEAR, 0, 0, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 2, 1, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_SPIN, 7, 0, 0));
        spins_pending.push_back(make_spin(rrs_pkg::KIND_CLEAR, $urandom, $urandom, $urandom));
        while (spins_pending.size() < TARGET_ITEMS)
            spins_pending.push_back(random_spin());

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (spins_pending.size() == 0);
        @(negedge clk);
        while (spin_ch.valid)
            @(negedge clk);
        while (reports_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d spins and %0d clears, %0d reports checked over %0d cycles",
                 spins_taken, clears_taken, reports_checked, cycles);
        $display("mismatches found: %0d", errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports still due", cycles, reports_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // spin driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (spin_taken)
            begin
                spin_gap = pause_len();
                if ($urandom_range(0, 99) == 0)
                    calm = ~calm;
            end
            if (!spin_ch.valid || spin_taken)
            begin
                if (spin_gap != 0)
                begin
                    spin_ch.valid <= 1'b0;
                    spin_gap--;
                end
                else if (spins_pending.size() != 0)
                begin
                    next_item = spins_pending.pop_front();
                    spin_ch.kind        <= next_item.kind;
                    spin_ch.wager       <= next_item.wager;
                    spin_ch.won         <= next_item.won;
                    spin_ch.consolation <= next_item.consolation;
                    spin_ch.valid       <= 1'b1;
                end
                else
                    spin_ch.valid <= 1'b0;
            end
        end
    end

    // report back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (report_taken)
                report_stall = pause_len();
            if (report_stall != 0)
            begin
                report_ch.ready <= 1'b0;
                report_stall--;
            end
            else
                report_ch.ready <= 1'b1;
        end
    end

    // monitor: predict on each accepted spin, check each accepted report
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            spin_taken   <= spin_ch.valid && spin_ch.ready;
            report_taken <= report_ch.valid && report_ch.ready;
            if (spin_ch.valid && spin_ch.ready)
            begin
                reports_due.push_back(apply_spin(make_spin(spin_ch.kind, spin_ch.wager,
                                                           spin_ch.won, spin_ch.consolation)));
                if (spin_ch.kind == rrs_pkg::KIND_CLEAR)
                    clears_taken++;
                else
                    spins_taken++;
            end
            if (report_ch.valid && report_ch.ready)
            begin
                if (reports_due.size() == 0)
                    note_fault("report with nothing due, spin_count",
                               64'(report_ch.spin_count), 64'(0));
                else
                begin
                    got = reports_due.pop_front();
                    reports_checked++;
                    if (report_ch.spin_count !== got.spins)
                        note_fault("spin_count", 64'(report_ch.spin_count), 64'(got.spins));
                    if (report_ch.win_count !== got.wins)
                        note_fault("win_count", 64'(report_ch.win_count), 64'(got.wins));
                    if (report_ch.wager_sum !== got.wagered)
                        note_fault("wager_sum", 64'(report_ch.wager_sum), 64'(got.wagered));
                    if (report_ch.won_sum !== got.paid)
                        note_fault("won_sum", 64'(report_ch.won_sum), 64'(got.paid));
                    if (report_ch.consolation_sum !== got.consoled)
                        note_fault("consolation_sum", 64'(report_ch.consolation_sum),
                                   64'(got.consoled));
                    if (report_ch.largest_return !== got.best)
                        note_fault("largest_return", 64'(report_ch.largest_return),
                                   64'(got.best));
                    if (report_ch.longest_losing_run !== got.longest_run)
                        note_fault("longest_losing_run", 64'(report_ch.longest_losing_run),
                                   64'(got.longest_run));
                    if (report_ch.avg_ratio !== got.mean)
                        note_fault("avg_ratio", 64'(report_ch.avg_ratio), 64'(got.mean));
                    if (report_ch.ratio_variance !== got.variance)
                        note_fault("ratio_variance", report_ch.ratio_variance, got.variance);
                end
            end
        end
    end

endmodule
